// File: sv/aisl_pkg.sv
package aisl_pkg;

    // Field widths fixed by the item format
    localparam int SAMPLE_W = 16;
    localparam int DIR_W    = 2;
    localparam int GAIN_W   = 10;
    localparam int POWER_W  = 8;
    localparam int ACC_Q8_W = 16;
    localparam int ERR_W    = SAMPLE_W + 2;
    localparam int PROD_W   = GAIN_W + 1 + ERR_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GAIN_W;

    // Power accumulator limit, 100.0 percent in Q8
    localparam int POWER_LIMIT_Q8 = 25600;
    localparam int POWER_LIMIT    = 100;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd205;

    // Item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Direction codes
    localparam logic signed [DIR_W-1:0] DIR_NONE    = 2'sb00;
    localparam logic signed [DIR_W-1:0] DIR_FORWARD = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_REVERSE = 2'sb11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR = 1'b1;

    // Update sequencer states
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_ERR  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_ACC  = 7'b0010000,
        ST_OUT0 = 7'b0100000,
        ST_OUT1 = 7'b1000000
    } state_t;

    // Divider handshake toward the sequencer
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

// File: sv/aisl_div.sv
module aisl_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  aisl_pkg::div_req_t       req,
    input  logic signed [DVD_W-1:0]  dividend,
    input  logic        [DVS_W-1:0]  divisor,
    output aisl_pkg::div_rsp_t       rsp,
    output logic signed [DVD_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               neg_reg,  neg_next;
    logic [DVD_W-1:0]   q_reg,    q_next;
    logic [DVS_W-1:0]   rem_reg,  rem_next;
    logic [DVS_W-1:0]   dvs_reg,  dvs_next;

    logic [DVS_W:0]     rem_sh;
    logic [DVS_W:0]     diff;

    // One restoring step per cycle on the magnitude, quotient bits shift in at the bottom
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, q_reg[DVD_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};

        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[DVD_W-1];
            q_next    = dividend[DVD_W-1] ? -dividend : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DVS_W]) begin
                rem_next = diff[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DVS_W-1:0];
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        neg_reg  <= neg_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    // Restore the sign: truncation toward zero
    assign quotient = neg_reg ? -q_reg : q_reg;
    assign rsp.done = done_reg;

endmodule

// File: sv/averaged_incremental_speed_loop_core.sv
// Averaged incremental proportional speed loop.
// Input channel (s_valid/s_ready): op 0 beats carry an encoder speed sample that is
// added to the averaging window (up to MAX_SAMPLES samples) and accepted one per
// cycle while the block is idle, with no result. Op 1 beats carry a target speed and
// direction and run a control update.
// Result channel (m_valid/m_ready): an update yields zero, one or two power
// commands; last_of_run marks the final one. A direction change yields a zero
// command first.
// Update sequence: with a non-empty window a serial divider forms the window average
// (SUM_W = 16 + clog2(MAX_SAMPLES + 1) quotient bits, 20 at the default), then the
// error, product and clamp are registered in turn before the first command shows
// up; with an empty window the divider is skipped. s_ready stays low from the update
// beat until the sequencer is back in idle, that is until its last command is taken
// (or at once after the clamp when the update yields no command).
// Configuration (cfg_wr_en/cfg_index/cfg_wdata): index 0 gain in Q8, index 1
// motor channel; write only while the block is idle.
// Reset (aresetn low, synchronous) clears the window, the power accumulator and
// the stored direction and restores the gain to 205. A stalled receiver holds
// the current command on the m_ ports and the block takes no new beat.
module averaged_incremental_speed_loop_core #(
    parameter int MAX_SAMPLES = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_op,
    input  logic signed [aisl_pkg::SAMPLE_W-1:0]   s_speed_sample,
    input  logic signed [aisl_pkg::SAMPLE_W-1:0]   s_target_speed,
    input  logic signed [aisl_pkg::DIR_W-1:0]      s_direction,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [aisl_pkg::POWER_W-1:0]    m_motor_power,
    output logic                                   m_motor_index,
    output logic                                   m_last_of_run,
    input  logic                                   cfg_wr_en,
    input  logic [aisl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [aisl_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    localparam int SW    = aisl_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SW + CNT_W;
    localparam int AQ_W  = aisl_pkg::ACC_Q8_W;
    localparam int EW    = aisl_pkg::ERR_W;
    localparam int PW    = aisl_pkg::PROD_W;
    localparam int AW    = aisl_pkg::ACC_W;
    localparam int OW    = aisl_pkg::POWER_W;

    aisl_pkg::state_t state_reg, state_next;

    // Control state
    logic [aisl_pkg::GAIN_W-1:0]          gain_reg,     gain_next;
    logic                                 motor_reg,    motor_next;
    logic signed [aisl_pkg::DIR_W-1:0]    prev_dir_reg, prev_dir_next;
    logic signed [AQ_W-1:0]               power_reg,    power_next;
    logic signed [SUM_W-1:0]              win_sum_reg,  win_sum_next;
    logic [CNT_W-1:0]                     win_cnt_reg,  win_cnt_next;
    logic signed [SW-1:0]                 latest_reg,   latest_next;

    // Working registers of one update
    logic signed [aisl_pkg::DIR_W-1:0]    dir_reg,      dir_next;
    logic signed [SW-1:0]                 target_reg,   target_next;
    logic                                 chg_reg,      chg_next;
    logic signed [SW-1:0]                 avg_reg,      avg_next;
    logic signed [EW-1:0]                 err_reg,      err_next;
    logic                                 err_nz_reg,   err_nz_next;
    logic signed [PW-1:0]                 prod_reg,     prod_next;
    logic signed [OW-1:0]                 pw_reg,       pw_next;
    logic signed [OW-1:0]                 out_pw_reg,   out_pw_next;
    logic                                 out_last_reg, out_last_next;

    aisl_pkg::div_req_t                   div_req;
    aisl_pkg::div_rsp_t                   div_rsp;
    logic signed [SUM_W-1:0]              div_quot;

    logic signed [aisl_pkg::DIR_W-1:0]    dir_dec;
    logic signed [EW-1:0]                 tgt_ext;
    logic signed [EW-1:0]                 avg_ext;
    logic signed [EW-1:0]                 err_calc;
    logic signed [AW-1:0]                 acc_sum;
    logic signed [AW-1:0]                 lim_pos;
    logic signed [AW-1:0]                 lim_neg;
    logic signed [AQ_W-1:0]               clamped;
    logic signed [AQ_W-1:0]               biased;

    aisl_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (win_sum_reg),
        .divisor  (win_cnt_reg),
        .rsp      (div_rsp),
        .quotient (div_quot)
    );

    // Decode direction: the -2 pattern saturates to reverse
    always_comb begin
        if (s_direction == aisl_pkg::DIR_FORWARD) begin
            dir_dec = aisl_pkg::DIR_FORWARD;
        end else if (s_direction == aisl_pkg::DIR_NONE) begin
            dir_dec = aisl_pkg::DIR_NONE;
        end else begin
            dir_dec = aisl_pkg::DIR_REVERSE;
        end
    end

    // Error, accumulate, clamp and truncate toward zero
    always_comb begin
        tgt_ext = {{(EW-SW){target_reg[SW-1]}}, target_reg};
        avg_ext = {{(EW-SW){avg_reg[SW-1]}}, avg_reg};
        if (dir_reg == aisl_pkg::DIR_FORWARD) begin
            err_calc = tgt_ext - avg_ext;
        end else if (dir_reg == aisl_pkg::DIR_REVERSE) begin
            err_calc = -tgt_ext - avg_ext;
        end else begin
            err_calc = '0;
        end

        lim_pos = AW'(aisl_pkg::POWER_LIMIT_Q8);
        lim_neg = -lim_pos;
        acc_sum = {{(AW-AQ_W){power_reg[AQ_W-1]}}, power_reg} + {prod_reg[PW-1], prod_reg};
        if (acc_sum > lim_pos) begin
            clamped = lim_pos[AQ_W-1:0];
        end else if (acc_sum < lim_neg) begin
            clamped = lim_neg[AQ_W-1:0];
        end else begin
            clamped = acc_sum[AQ_W-1:0];
        end
        biased = clamped + (clamped[AQ_W-1] ? AQ_W'(255) : AQ_W'(0));
    end

    // Sequencer and state update
    always_comb begin
        state_next    = state_reg;
        gain_next     = gain_reg;
        motor_next    = motor_reg;
        prev_dir_next = prev_dir_reg;
        power_next    = power_reg;
        win_sum_next  = win_sum_reg;
        win_cnt_next  = win_cnt_reg;
        latest_next   = latest_reg;
        dir_next      = dir_reg;
        target_next   = target_reg;
        chg_next      = chg_reg;
        avg_next      = avg_reg;
        err_next      = err_reg;
        err_nz_next   = err_nz_reg;
        prod_next     = prod_reg;
        pw_next       = pw_reg;
        out_pw_next   = out_pw_reg;
        out_last_next = out_last_reg;
        div_req.start = 1'b0;

        // Take register writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                aisl_pkg::REG_GAIN:  gain_next  = cfg_wdata[aisl_pkg::GAIN_W-1:0];
                aisl_pkg::REG_MOTOR: motor_next = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            aisl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == aisl_pkg::OP_SAMPLE) begin
                        // Record sample, fill window while there is room
                        latest_next = s_speed_sample;
                        if (win_cnt_reg < CNT_W'(MAX_SAMPLES)) begin
                            win_sum_next = win_sum_reg +
                                {{(SUM_W-SW){s_speed_sample[SW-1]}}, s_speed_sample};
                            win_cnt_next = win_cnt_reg + 1'b1;
                        end
                    end else begin
                        // Latch update, handle direction change, launch average (latest sample if window empty)
                        dir_next    = dir_dec;
                        target_next = s_target_speed;
                        chg_next    = (dir_dec != prev_dir_reg);
                        if (dir_dec != prev_dir_reg) begin
                            prev_dir_next = dir_dec;
                            power_next    = '0;
                        end
                        if (win_cnt_reg != '0) begin
                            div_req.start = 1'b1;
                            state_next    = aisl_pkg::ST_DIV;
                        end else begin
                            avg_next   = latest_reg;
                            state_next = aisl_pkg::ST_ERR;
                        end
                        win_sum_next = '0;
                        win_cnt_next = '0;
                    end
                end
            end
            aisl_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    avg_next   = div_quot[SW-1:0];
                    state_next = aisl_pkg::ST_ERR;
                end
            end
            aisl_pkg::ST_ERR: begin
                err_next    = err_calc;
                err_nz_next = (err_calc != '0);
                state_next  = aisl_pkg::ST_MUL;
            end
            aisl_pkg::ST_MUL: begin
                prod_next  = PW'($signed({1'b0, gain_reg})) * PW'(err_reg);
                state_next = aisl_pkg::ST_ACC;
            end
            aisl_pkg::ST_ACC: begin
                pw_next = biased[AQ_W-1:AQ_W-OW];
                if (err_nz_reg) begin
                    power_next = clamped;
                end
                if (chg_reg) begin
                    out_pw_next   = '0;
                    out_last_next = !err_nz_reg;
                    state_next    = aisl_pkg::ST_OUT0;
                end else if (err_nz_reg) begin
                    out_pw_next   = biased[AQ_W-1:AQ_W-OW];
                    out_last_next = 1'b1;
                    state_next    = aisl_pkg::ST_OUT1;
                end else begin
                    state_next = aisl_pkg::ST_IDLE;
                end
            end
            aisl_pkg::ST_OUT0: begin
                if (m_ready) begin
                    if (err_nz_reg) begin
                        out_pw_next   = pw_reg;
                        out_last_next = 1'b1;
                        state_next    = aisl_pkg::ST_OUT1;
                    end else begin
                        state_next = aisl_pkg::ST_IDLE;
                    end
                end
            end
            aisl_pkg::ST_OUT1: begin
                if (m_ready) begin
                    state_next = aisl_pkg::ST_IDLE;
                end
            end
            default: state_next = aisl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= aisl_pkg::ST_IDLE;
            gain_reg     <= aisl_pkg::GAIN_RESET;
            motor_reg    <= 1'b0;
            prev_dir_reg <= aisl_pkg::DIR_NONE;
            power_reg    <= '0;
            win_sum_reg  <= '0;
            win_cnt_reg  <= '0;
            latest_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            gain_reg     <= gain_next;
            motor_reg    <= motor_next;
            prev_dir_reg <= prev_dir_next;
            power_reg    <= power_next;
            win_sum_reg  <= win_sum_next;
            win_cnt_reg  <= win_cnt_next;
            latest_reg   <= latest_next;
        end
    end

    always_ff @(posedge aclk) begin
        dir_reg      <= dir_next;
        target_reg   <= target_next;
        chg_reg      <= chg_next;
        avg_reg      <= avg_next;
        err_reg      <= err_next;
        err_nz_reg   <= err_nz_next;
        prod_reg     <= prod_next;
        pw_reg       <= pw_next;
        out_pw_reg   <= out_pw_next;
        out_last_reg <= out_last_next;
    end

    assign s_ready       = (state_reg == aisl_pkg::ST_IDLE);
    assign m_valid       = (state_reg == aisl_pkg::ST_OUT0) || (state_reg == aisl_pkg::ST_OUT1);
    assign m_motor_power = out_pw_reg;
    assign m_motor_index = motor_reg;
    assign m_last_of_run = out_last_reg;

`ifndef ASSERT_OFF
    a_busy_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a command is pending");

    a_update_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == aisl_pkg::OP_UPDATE)) |=> !s_ready)
        else $error("update beat did not start the sequencer");

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        win_cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("window count beyond its size");

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (power_reg <= AQ_W'(aisl_pkg::POWER_LIMIT_Q8)) &&
        (power_reg >= -AQ_W'(aisl_pkg::POWER_LIMIT_Q8)))
        else $error("power accumulator outside the clamp");

    a_power_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_motor_power <= OW'(aisl_pkg::POWER_LIMIT)) &&
                     (m_motor_power >= -OW'(aisl_pkg::POWER_LIMIT))))
        else $error("power command outside the percent range");
`endif

endmodule
